[rtl/ssd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  // Fraction bits of the two segment parameters (unsigned Q1.32, range [0, 1])
  localparam int FRAC_BITS = 32;

  // Depth of the queue between front and back, and of the result queue
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // Queue status seen by the neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } ssd_qstat_t;

endpackage

`default_nettype wire

[rtl/ssd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output ssd_pkg::ssd_qstat_t stat
);
  import ssd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r, wptr_nxt, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // pointer wrap
  assign wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
  assign rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_nxt;
      end
      if (pop) begin
        rptr_r <= rptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

[rtl/ssd_wmul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Signed WIDTH x WIDTH multiply split into four half-width partial products,
// two stages: partial products, then the shifted sum.
module ssd_wmul #(
  parameter int WIDTH = 51
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WIDTH-1:0]   a,
  input  logic signed [WIDTH-1:0]   b,
  output logic signed [2*WIDTH-1:0] p
);

  localparam int LO = (WIDTH + 1) / 2;
  localparam int HI = WIDTH - LO;
  localparam int PW = 2 * WIDTH;

  logic signed [LO:0]       al, bl;
  logic signed [HI-1:0]     ah, bh;
  logic signed [2*LO+1:0]   pll_r;
  logic signed [LO+HI:0]    plh_r, phl_r;
  logic signed [2*HI-1:0]   phh_r;
  logic signed [PW-1:0]     ell, elh, ehl, ehh, p_nxt;

  // low halves as unsigned, high halves keep the sign
  assign al = $signed({1'b0, a[LO-1:0]});
  assign bl = $signed({1'b0, b[LO-1:0]});
  assign ah = $signed(a[WIDTH-1:LO]);
  assign bh = $signed(b[WIDTH-1:LO]);

  assign ell   = PW'(pll_r);
  assign elh   = PW'(plh_r);
  assign ehl   = PW'(phl_r);
  assign ehh   = PW'(phh_r);
  assign p_nxt = (ehh <<< (2 * LO)) + ((elh + ehl) <<< LO) + ell;

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= al * bl;
      plh_r <= al * bh;
      phl_r <= ah * bl;
      phh_r <= ah * bh;
      p     <= p_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/ssd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Front: differences, dot products, denominator and numerators, then the
// two clamping steps. Eight stages, all advanced by en.
module ssd_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   push,
  input  logic [COORD_WIDTH-1:0] first_start  [3],
  input  logic [COORD_WIDTH-1:0] first_end    [3],
  input  logic [COORD_WIDTH-1:0] second_start [3],
  input  logic [COORD_WIDTH-1:0] second_end   [3],
  output logic                   out_valid,
  output logic [9*(COORD_WIDTH+1)+8*(2*COORD_WIDTH+3)-1:0] out_word
);

  localparam int D  = COORD_WIDTH + 1;
  localparam int DW = 2 * COORD_WIDTH + 3;
  localparam int NW = 2 * DW;
  localparam int NST = 8;

  // which dot products feed the six wide multipliers: ac, bb, be, cd, ae, bd
  localparam int MA [6] = '{0, 1, 1, 2, 0, 1};
  localparam int MB [6] = '{2, 1, 4, 3, 4, 3};

  logic                  fv_r [NST];
  logic signed [D-1:0]   diff_nxt [9];
  logic signed [D-1:0]   vec_r [NST][9];
  logic signed [2*D-1:0] prod_nxt [15];
  logic signed [2*D-1:0] prod_r [15];
  logic signed [DW-1:0]  dot_nxt [5];
  logic signed [DW-1:0]  dk_r [5][5];
  logic signed [NW-1:0]  wm_p [6];
  logic signed [NW-1:0]  den_r, sn_r, tn_r;
  logic signed [NW-1:0]  ee7, cc7, bb7;
  logic                  den_pos;
  logic signed [NW-1:0]  sn7_nxt, sd7_nxt, tn7_nxt, td7_nxt;
  logic signed [NW-1:0]  sn7_r, sd7_r, tn7_r, td7_r;
  logic signed [NW-1:0]  aa8, bb8, nd8, m8, sel8;
  logic                  tneg, tbig;
  logic signed [NW-1:0]  sn8_nxt, sd8_nxt, tn8_nxt, td8_nxt;
  logic signed [NW-1:0]  sn8_r, sd8_r, tn8_r, td8_r;

  // direction vectors du, dv and start offset dw
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_nxt[k]     = $signed({first_end[k][COORD_WIDTH-1], first_end[k]})
                      - $signed({first_start[k][COORD_WIDTH-1], first_start[k]});
      diff_nxt[3 + k] = $signed({second_end[k][COORD_WIDTH-1], second_end[k]})
                      - $signed({second_start[k][COORD_WIDTH-1], second_start[k]});
      diff_nxt[6 + k] = $signed({first_start[k][COORD_WIDTH-1], first_start[k]})
                      - $signed({second_start[k][COORD_WIDTH-1], second_start[k]});
    end
  end

  // per-axis products: uu, uv, vv, uw, vw
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k]      = vec_r[0][k] * vec_r[0][k];
      prod_nxt[3 + k]  = vec_r[0][k] * vec_r[0][3 + k];
      prod_nxt[6 + k]  = vec_r[0][3 + k] * vec_r[0][3 + k];
      prod_nxt[9 + k]  = vec_r[0][k] * vec_r[0][6 + k];
      prod_nxt[12 + k] = vec_r[0][3 + k] * vec_r[0][6 + k];
    end
  end

  // dot products aa, bb, cc, dd, ee
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      dot_nxt[i] = DW'(prod_r[3 * i]) + DW'(prod_r[3 * i + 1]) + DW'(prod_r[3 * i + 2]);
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_wmul
    ssd_wmul #(.WIDTH(DW)) u_wmul (
      .clk (clk),
      .en  (en),
      .a   (dk_r[0][MA[g]]),
      .b   (dk_r[0][MB[g]]),
      .p   (wm_p[g])
    );
  end

  // first clamp: parallel case and s outside [0, 1]
  always_comb begin
    ee7     = NW'(dk_r[3][4]);
    cc7     = NW'(dk_r[3][2]);
    bb7     = NW'(dk_r[3][1]);
    den_pos = !den_r[NW-1] && (den_r != '0);
    sn7_nxt = sn_r;
    sd7_nxt = den_r;
    tn7_nxt = tn_r;
    td7_nxt = den_r;
    if (!den_pos) begin
      sn7_nxt = '0;
      sd7_nxt = NW'(1);
      tn7_nxt = ee7;
      td7_nxt = cc7;
    end else if (sn_r[NW-1]) begin
      sn7_nxt = '0;
      tn7_nxt = ee7;
      td7_nxt = cc7;
    end else if (sn_r > den_r) begin
      sn7_nxt = den_r;
      tn7_nxt = ee7 + bb7;
      td7_nxt = cc7;
    end
  end

  // second clamp: t outside [0, 1] pulls s back onto its segment
  always_comb begin
    aa8     = NW'(dk_r[4][0]);
    bb8     = NW'(dk_r[4][1]);
    nd8     = -NW'(dk_r[4][3]);
    m8      = nd8 + bb8;
    tneg    = tn7_r[NW-1];
    tbig    = tn7_r > td7_r;
    sel8    = tneg ? nd8 : m8;
    sn8_nxt = sn7_r;
    sd8_nxt = sd7_r;
    tn8_nxt = tn7_r;
    td8_nxt = td7_r;
    if (tneg || tbig) begin
      tn8_nxt = tneg ? '0 : td7_r;
      if (sel8[NW-1]) begin
        sn8_nxt = '0;
      end else if (sel8 > aa8) begin
        sn8_nxt = sd7_r;
      end else begin
        sn8_nxt = sel8;
        sd8_nxt = aa8;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        fv_r[i] <= 1'b0;
      end
    end else if (en) begin
      fv_r[0] <= push;
      for (int i = 1; i < NST; i++) begin
        fv_r[i] <= fv_r[i - 1];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      vec_r[0] <= diff_nxt;
      for (int i = 1; i < NST; i++) begin
        vec_r[i] <= vec_r[i - 1];
      end
      prod_r   <= prod_nxt;
      dk_r[0]  <= dot_nxt;
      for (int i = 1; i < 5; i++) begin
        dk_r[i] <= dk_r[i - 1];
      end
      den_r <= wm_p[0] - wm_p[1];
      sn_r  <= wm_p[2] - wm_p[3];
      tn_r  <= wm_p[4] - wm_p[5];
      sn7_r <= sn7_nxt;
      sd7_r <= sd7_nxt;
      tn7_r <= tn7_nxt;
      td7_r <= td7_nxt;
      sn8_r <= sn8_nxt;
      sd8_r <= sd8_nxt;
      tn8_r <= tn8_nxt;
      td8_r <= td8_nxt;
    end
  end

  // word to the back: vectors, then s num/den, t num/den
  always_comb begin
    out_word[3*NW +: NW] = sn8_r;
    out_word[2*NW +: NW] = sd8_r;
    out_word[NW +: NW]   = tn8_r;
    out_word[0 +: NW]    = td8_r;
    for (int k = 0; k < 9; k++) begin
      out_word[4*NW + k*D +: D] = vec_r[NST-1][k];
    end
  end

  assign out_valid = fv_r[NST-1];

endmodule

`default_nettype wire

[rtl/ssd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

// Back: two restoring dividers for s and t, closest-point difference,
// squared length, digit-by-digit square root and saturation.
module ssd_back #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [9*(COORD_WIDTH+1)+8*(2*COORD_WIDTH+3)-1:0] in_word,
  output logic                   out_valid,
  output logic [COORD_WIDTH:0]   out_dist
);
  import ssd_pkg::*;

  localparam int D    = COORD_WIDTH + 1;
  localparam int DW   = 2 * COORD_WIDTH + 3;
  localparam int NW   = 2 * DW;
  localparam int CW   = D + FRAC_BITS + 2;
  localparam int SUMW = 2 * CW + 2;
  localparam int RB   = COORD_WIDTH + 3;
  localparam int SQW  = 2 * RB;
  localparam int REMW = RB + 3;
  localparam int SP   = FRAC_BITS + 1;
  localparam int SO   = FRAC_BITS + 7 + RB;
  localparam int NB   = SO + 1;

  logic                 bv_r [NB];
  logic signed [D-1:0]  vec_in [9];
  logic signed [D-1:0]  vec_r [SP+1][9];
  logic signed [NW-1:0] num_in [2];
  logic signed [NW-1:0] den_in [2];
  logic [NW-1:0]        rem_r [2][FRAC_BITS+1];
  logic [NW-1:0]        dvs_r [2][FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_r   [2][FRAC_BITS+1];
  logic                 zf_r  [2][FRAC_BITS+1];
  logic                 of_r  [2][FRAC_BITS+1];
  logic [FRAC_BITS:0]   par_r [2];
  logic signed [CW-1:0] pu_r [3];
  logic signed [CW-1:0] pv_r [3];
  logic signed [D-1:0]  mw_r [3];
  logic signed [CW-1:0] c_r [3];
  logic signed [2*CW-1:0] sq_w [3];
  logic [SUMW-1:0]      sum_nxt;
  logic [SQW-1:0]       rad_r  [RB+1];
  logic [REMW-1:0]      srem_r [RB+1];
  logic [RB-1:0]        root_r [RB+1];
  logic                 sat;

  // unpack the word from the front
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      vec_in[k] = $signed(in_word[4*NW + k*D +: D]);
    end
    num_in[0] = $signed(in_word[3*NW +: NW]);
    den_in[0] = $signed(in_word[2*NW +: NW]);
    num_in[1] = $signed(in_word[NW +: NW]);
    den_in[1] = $signed(in_word[0 +: NW]);
  end

  // dividers: one quotient bit per stage
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic zf_nxt, of_nxt;

    // guard: non-positive operand gives 0, num at or above den gives 1.0
    assign zf_nxt = num_in[l][NW-1] || (num_in[l] == '0)
                 || den_in[l][NW-1] || (den_in[l] == '0);
    assign of_nxt = !zf_nxt && (num_in[l] >= den_in[l]);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[l][0] <= num_in[l];
        dvs_r[l][0] <= den_in[l];
        q_r[l][0]   <= '0;
        zf_r[l][0]  <= zf_nxt;
        of_r[l][0]  <= of_nxt;
      end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
      logic [NW-1:0] dbl;
      logic          q_bit;

      assign dbl   = {rem_r[l][k-1][NW-2:0], 1'b0};
      assign q_bit = dbl >= dvs_r[l][k-1];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[l][k] <= q_bit ? dbl - dvs_r[l][k-1] : dbl;
          dvs_r[l][k] <= dvs_r[l][k-1];
          q_r[l][k]   <= {q_r[l][k-1][FRAC_BITS-2:0], q_bit};
          zf_r[l][k]  <= zf_r[l][k-1];
          of_r[l][k]  <= of_r[l][k-1];
        end
      end
    end
  end

  // squared length of the closest-point difference
  for (genvar k = 0; k < 3; k++) begin : g_sq
    ssd_wmul #(.WIDTH(CW)) u_wmul (
      .clk (clk),
      .en  (en),
      .a   (c_r[k]),
      .b   (c_r[k]),
      .p   (sq_w[k])
    );
  end

  assign sum_nxt = {2'b00, sq_w[0]} + {2'b00, sq_w[1]} + {2'b00, sq_w[2]};

  // square root: two radicand bits per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= sum_nxt[2*FRAC_BITS +: SQW];
      srem_r[0] <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= RB; j++) begin : g_sqrt
    logic [REMW-1:0] rs, trial;
    logic            r_bit;

    assign rs    = {srem_r[j-1][REMW-3:0], rad_r[j-1][SQW-1:SQW-2]};
    assign trial = {1'b0, root_r[j-1], 2'b01};
    assign r_bit = rs >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j]  <= {rad_r[j-1][SQW-3:0], 2'b00};
        srem_r[j] <= r_bit ? rs - trial : rs;
        root_r[j] <= {root_r[j-1][RB-2:0], r_bit};
      end
    end
  end

  assign sat = (root_r[RB][RB-1:COORD_WIDTH+1] != '0);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        bv_r[i] <= 1'b0;
      end
    end else if (en) begin
      bv_r[0] <= in_valid;
      for (int i = 1; i < NB; i++) begin
        bv_r[i] <= bv_r[i - 1];
      end
    end
  end

  // parameters, products, difference vector, result
  always_ff @(posedge clk) begin
    if (en) begin
      vec_r[0] <= vec_in;
      for (int i = 1; i <= SP; i++) begin
        vec_r[i] <= vec_r[i - 1];
      end
      for (int l = 0; l < 2; l++) begin
        if (zf_r[l][FRAC_BITS]) begin
          par_r[l] <= '0;
        end else if (of_r[l][FRAC_BITS]) begin
          par_r[l] <= {1'b1, {FRAC_BITS{1'b0}}};
        end else begin
          par_r[l] <= {1'b0, q_r[l][FRAC_BITS]};
        end
      end
      for (int k = 0; k < 3; k++) begin
        pu_r[k] <= vec_r[SP][k] * $signed({1'b0, par_r[0]});
        pv_r[k] <= vec_r[SP][3 + k] * $signed({1'b0, par_r[1]});
        mw_r[k] <= vec_r[SP][6 + k];
        c_r[k]  <= $signed({{2{mw_r[k][D-1]}}, mw_r[k], {FRAC_BITS{1'b0}}})
                 + pu_r[k] - pv_r[k];
      end
      out_dist <= sat ? '1 : root_r[RB][COORD_WIDTH:0];
    end
  end

  assign out_valid = bv_r[SO];

endmodule

`default_nettype wire

[rtl/segment_segment_distance.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shortest distance between two 3D segments.
// Input: a word of twelve signed Q16.8 endpoint coordinates is taken at a
// clock edge with push high and full low. Output: the distance, unsigned
// Q17.8 rounded down, sits on out_gap_distance while empty is low and is
// taken at an edge with pop high.
// Throughput: one word per cycle while full stays low. A word runs
// through 8 front stages, the middle queue, 32 divider stages (one
// quotient bit each), the closest-point math and COORD_WIDTH + 3
// square root stages.
// The front and the back each run as one pipeline; a 4-word queue between
// them and a 2-word result queue let each side stall on its own.
// When the receiver stops popping, the result queue fills, the back halts,
// then the middle queue fills and full rises; no word is lost.
// Reset (synchronous, rst_n low) empties both queues and drops all words
// in flight; full is low and empty high in the cycle after.
module segment_segment_distance #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [COORD_WIDTH-1:0] in_first_start_x,
  input  logic [COORD_WIDTH-1:0] in_first_start_y,
  input  logic [COORD_WIDTH-1:0] in_first_start_z,
  input  logic [COORD_WIDTH-1:0] in_first_end_x,
  input  logic [COORD_WIDTH-1:0] in_first_end_y,
  input  logic [COORD_WIDTH-1:0] in_first_end_z,
  input  logic [COORD_WIDTH-1:0] in_second_start_x,
  input  logic [COORD_WIDTH-1:0] in_second_start_y,
  input  logic [COORD_WIDTH-1:0] in_second_start_z,
  input  logic [COORD_WIDTH-1:0] in_second_end_x,
  input  logic [COORD_WIDTH-1:0] in_second_end_y,
  input  logic [COORD_WIDTH-1:0] in_second_end_z,
  output logic                   empty,
  input  logic                   pop,
  output logic [COORD_WIDTH:0]   out_gap_distance
);
  import ssd_pkg::*;

  localparam int WORDW = 9 * (COORD_WIDTH + 1) + 8 * (2 * COORD_WIDTH + 3);

  logic [COORD_WIDTH-1:0] p0 [3];
  logic [COORD_WIDTH-1:0] p1 [3];
  logic [COORD_WIDTH-1:0] q0 [3];
  logic [COORD_WIDTH-1:0] q1 [3];
  logic                   fe, be, f_valid, b_valid;
  logic [WORDW-1:0]       f_word, m_word;
  logic [COORD_WIDTH:0]   b_dist;
  ssd_qstat_t             mid_stat, out_stat;

  assign p0[0] = in_first_start_x;
  assign p0[1] = in_first_start_y;
  assign p0[2] = in_first_start_z;
  assign p1[0] = in_first_end_x;
  assign p1[1] = in_first_end_y;
  assign p1[2] = in_first_end_z;
  assign q0[0] = in_second_start_x;
  assign q0[1] = in_second_start_y;
  assign q0[2] = in_second_start_z;
  assign q1[0] = in_second_end_x;
  assign q1[1] = in_second_end_y;
  assign q1[2] = in_second_end_z;

  // each pipeline halts only when its last stage holds a word it cannot hand on
  assign fe   = !(f_valid && mid_stat.full);
  assign be   = !(b_valid && out_stat.full);
  assign full = !fe;

  ssd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (fe),
    .push         (push),
    .first_start  (p0),
    .first_end    (p1),
    .second_start (q0),
    .second_end   (q1),
    .out_valid    (f_valid),
    .out_word     (f_word)
  );

  ssd_fifo #(.WIDTH(WORDW), .DEPTH(MID_DEPTH)) u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid && fe),
    .wdata (f_word),
    .pop   (be && !mid_stat.empty),
    .rdata (m_word),
    .stat  (mid_stat)
  );

  ssd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (be),
    .in_valid  (!mid_stat.empty),
    .in_word   (m_word),
    .out_valid (b_valid),
    .out_dist  (b_dist)
  );

  ssd_fifo #(.WIDTH(COORD_WIDTH + 1), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_valid && be),
    .wdata (b_dist),
    .pop   (pop && !out_stat.empty),
    .rdata (out_gap_distance),
    .stat  (out_stat)
  );

  assign empty = out_stat.empty;

endmodule

`default_nettype wire

[rtl/ssd_check.sv]
`timescale 1ns / 1ps
`default_nettype none

module ssd_check #(
  parameter int COORD_WIDTH = 24
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [COORD_WIDTH:0] out_gap_distance
);

  // reset leaves the result queue empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // reset leaves the input side open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("full high after reset");

  // a waiting result word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_gap_distance))
    else $error("result word changed while stalled");

  // a push refused while full, with a result waiting and no pop, leaves full high or the result queue non-empty
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    full && push && !pop && !empty |=> full || !empty)
    else $error("input side and result side both drained without a pop");

endmodule

bind segment_segment_distance ssd_check #(.COORD_WIDTH(COORD_WIDTH)) u_ssd_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .push             (push),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_gap_distance (out_gap_distance)
);

`default_nettype wire
